/* design/lpd_pkg.sv */
`default_nettype none
package lpd_pkg;

    // field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_W     = 24;
    localparam int unsigned SIZE_W    = 24;
    localparam int unsigned TYPE_W    = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned ERR_W     = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // stream packing
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned M_TUSER_W = 2;

    // length prefix size in bytes
    localparam int unsigned LENGTH_BYTES_DEF = 4;

    // register reset values
    localparam logic [CFG_W-1:0]  MAX_SIZE_RST = 24'd65536;
    localparam logic [CFG_W-1:0]  TIMEOUT_RST  = 24'd0;
    localparam logic [TYPE_W-1:0] MAX_TYPE_RST = 8'd8;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SIZE = 2'd0,
        CFG_TIMEOUT  = 2'd1,
        CFG_MAX_TYPE = 2'd2
    } t_cfg_idx;

    // input beat kinds
    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } t_req;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_LENGTH  = 2'd0,
        ERR_TYPE    = 2'd1,
        ERR_TIMEOUT = 2'd2
    } t_err;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_LENGTH  = 3'b001,
        PH_TYPE    = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef struct packed {
        logic [SIZE_W-1:0] max_packet_size;
        logic [CFG_W-1:0]  idle_timeout_ticks;
        logic [TYPE_W-1:0] max_valid_type;
    } t_cfg;

    typedef struct packed {
        t_req              req_type;
        logic [BYTE_W-1:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_kind             out_kind;
        logic [TYPE_W-1:0] packet_type;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
        t_err              error_code;
    } t_result;

endpackage
`default_nettype wire

/* design/lpd_cfg.sv */
`default_nettype none
module lpd_cfg
    import lpd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_packet_size    <= MAX_SIZE_RST;
            r_cfg.idle_timeout_ticks <= TIMEOUT_RST;
            r_cfg.max_valid_type     <= MAX_TYPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAX_SIZE: r_cfg.max_packet_size    <= i_cfg_wdata;
                CFG_TIMEOUT:  r_cfg.idle_timeout_ticks <= i_cfg_wdata;
                CFG_MAX_TYPE: r_cfg.max_valid_type     <= i_cfg_wdata[TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* design/lpd_in_stage.sv */
`default_nettype none
module lpd_in_stage
    import lpd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_valid,
    input  wire logic  i_take,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

/* design/lpd_parse.sv */
`default_nettype none
module lpd_parse
    import lpd_pkg::*;
#(
    parameter int unsigned LENGTH_BYTES = LENGTH_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int unsigned LW = 8 * LENGTH_BYTES;
    localparam int unsigned IW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
    localparam int unsigned CW = (LW > SIZE_W) ? LW : SIZE_W;
    localparam logic [IW-1:0] IDX_LAST = IW'(LENGTH_BYTES - 1);

    t_phase            r_phase,  n_phase;
    logic [LW-1:0]     r_shift,  n_shift;
    logic [IW-1:0]     r_idx,    n_idx;
    logic [SIZE_W-1:0] r_rem,    n_rem;
    logic [TYPE_W-1:0] r_type,   n_type;
    logic              r_failed, n_failed;
    logic [CFG_W-1:0]  r_idle,   n_idle;

    logic [LW-1:0]     shift_in;
    logic [TYPE_W-1:0] rx;

    // little-endian length bytes shift in from the top
    assign rx       = i_item.rx_byte;
    assign shift_in = (r_shift >> 8) | (LW'(rx) << (8 * (LENGTH_BYTES - 1)));

    // next state and result for one beat
    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_type      = r_type;
        n_failed    = r_failed;
        n_idle      = r_idle;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (!r_failed) begin
            if (i_item.req_type == REQ_BYTE) begin
                n_idle = i_cfg.idle_timeout_ticks;
                unique case (r_phase)
                    PH_LENGTH: begin
                        n_shift = shift_in;
                        n_idx   = r_idx + 1'b1;
                        if (r_idx == IDX_LAST) begin
                            n_idx = '0;
                            if (shift_in[LW-1] ||
                                (CW'(shift_in) > CW'(i_cfg.max_packet_size))) begin
                                n_failed          = 1'b1;
                                o_res_valid       = 1'b1;
                                o_res.out_kind    = KIND_ERROR;
                                o_res.error_code  = ERR_LENGTH;
                            end else begin
                                n_rem   = SIZE_W'(shift_in);
                                n_phase = PH_TYPE;
                            end
                        end
                    end
                    PH_TYPE: begin
                        n_type = rx;
                        if (rx > i_cfg.max_valid_type) begin
                            n_failed          = 1'b1;
                            o_res_valid       = 1'b1;
                            o_res.out_kind    = KIND_ERROR;
                            o_res.packet_type = rx;
                            o_res.error_code  = ERR_TYPE;
                        end else if (r_rem == '0) begin
                            n_phase           = PH_LENGTH;
                            o_res_valid       = 1'b1;
                            o_res.out_kind    = KIND_EMPTY;
                            o_res.packet_type = rx;
                            o_res.last        = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_rem             = r_rem - 1'b1;
                        o_res_valid       = 1'b1;
                        o_res.out_kind    = KIND_DATA;
                        o_res.packet_type = r_type;
                        o_res.data_byte   = rx;
                        if (r_rem == SIZE_W'(1)) begin
                            o_res.last = 1'b1;
                            n_phase    = PH_LENGTH;
                        end
                    end
                    default: begin
                        n_phase = PH_LENGTH;
                    end
                endcase
            end else if (r_idle != '0) begin
                // idle timer runs down on ticks
                n_idle = r_idle - 1'b1;
                if (r_idle == CFG_W'(1)) begin
                    n_failed          = 1'b1;
                    o_res_valid       = 1'b1;
                    o_res.out_kind    = KIND_ERROR;
                    o_res.packet_type = (r_phase == PH_PAYLOAD) ? r_type : '0;
                    o_res.error_code  = ERR_TIMEOUT;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LENGTH;
            r_idx    <= '0;
            r_rem    <= '0;
            r_type   <= '0;
            r_failed <= 1'b0;
            r_idle   <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_rem    <= n_rem;
            r_type   <= n_type;
            r_failed <= n_failed;
            r_idle   <= n_idle;
        end
    end

    // length shift register
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_shift <= n_shift;
        end
    end

endmodule
`default_nettype wire

/* design/lpd_out_stage.sv */
`default_nettype none
module lpd_out_stage
    import lpd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

/* design/length_prefixed_packet_deframer_core.sv */
// a result beat passes the input register, then the result register, before it is presented
// throughput: one beat per cycle while the result register is free, input register -> parse logic -> result register
// input keeps flowing while a result waits, until both registers are full
// reset: synchronous active low; clears phase, counters, timer, error flag
// and restores register defaults; no clearing pass
`default_nettype none
module length_prefixed_packet_deframer_core
    import lpd_pkg::*;
#(
    parameter int unsigned LENGTH_BYTES = LENGTH_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,   // [0] req_type
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,   // [7:0] packet_type, [15:8] data_byte,
                                                      // [17:16] error_code, [23:18] zero
    output logic [M_TUSER_W-1:0]      m_axis_tuser,   // [1:0] out_kind
    output logic                      m_axis_tlast,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cfg    cfg;
    t_item   s_item;
    t_item   q_item;
    t_result res;
    t_result out_res;
    logic    q_valid;
    logic    take;
    logic    out_free;
    logic    res_valid;

    assign s_item.req_type = t_req'(s_axis_tuser[0]);
    assign s_item.rx_byte  = s_axis_tdata[BYTE_W-1:0];

    lpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lpd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (s_item),
        .o_valid (q_valid),
        .i_take  (take),
        .o_item  (q_item)
    );

    // a held beat is processed whenever the result register can take it
    assign take = q_valid && out_free;

    lpd_parse #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (take),
        .i_item      (q_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    // result beat packing
    assign m_axis_tdata = {6'b0, out_res.error_code, out_res.data_byte, out_res.packet_type};
    assign m_axis_tuser = out_res.out_kind;
    assign m_axis_tlast = out_res.last;

endmodule
`default_nettype wire

/* sim/length_prefixed_packet_deframer_core_tb.sv */
`timescale 1ns / 1ps
module length_prefixed_packet_deframer_core_tb;
    import lpd_pkg::*;

    // unmapped register index, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_IDX = 2'd3;
    localparam logic [1:0]           LEN_IDX_END  = 2'(LENGTH_BYTES_DEF);
    localparam int                   SIGN_BIT     = 8 * LENGTH_BYTES_DEF - 1;
    localparam int                   STALL_LIMIT  = 5000;

    // error injected at the very end, since any error locks the block until reset
    typedef enum int {
        FAULT_NEG_LEN,
        FAULT_BIG_LEN,
        FAULT_BAD_TYPE,
        FAULT_TIMEOUT
    } t_fault;

    // parser state as seen from the stream
    typedef struct packed {
        t_phase            ph;
        logic [31:0]       len_acc;
        logic [1:0]        len_idx;
        logic [SIZE_W-1:0] remain;
        logic [TYPE_W-1:0] cur_type;
        logic              failed;
        logic [CFG_W-1:0]  idle_cnt;
    } t_parser;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // [7:0] rx_byte
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;   // [0] req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // [7:0] packet_type, [15:8] data_byte,
                                                // [17:16] error_code, [23:18] zero
    logic [M_TUSER_W-1:0] m_axis_tuser;         // [1:0] out_kind
    logic                 m_axis_tlast;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr    = '0;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;

    t_item   rx_stream_q[$];
    t_result deframed_q[$];
    t_cfg    regs;
    t_parser plan_st;
    t_parser live_st;

    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      n_live_items   = 0;
    int      n_beats_in     = 0;
    int      n_payload      = 0;
    int      n_empty        = 0;
    int      n_faults       = 0;
    int      n_fail         = 0;
    int      stall_cycles   = 0;
    t_fault  fault_kind;
    string   fault_name;

    t_item   next_beat;
    t_item   seen_beat;
    t_result want_res;
    t_result got_res;
    t_result pred_res;
    logic    pred_hit;

    length_prefixed_packet_deframer_core #(
        .LENGTH_BYTES (LENGTH_BYTES_DEF)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one input beat through the deframer, returns the next parser state
    function automatic t_parser deframe_step(input t_parser st, input t_cfg c,
                                             input t_item it, output logic hit,
                                             output t_result res);
        t_parser n;
        n   = st;
        hit = 1'b0;
        res = '0;
        if (st.failed)
            return n;
        if (it.req_type == REQ_TICK) begin
            // idle timer, stopped at zero
            if (st.idle_cnt == '0)
                return n;
            n.idle_cnt = st.idle_cnt - 1'b1;
            if (n.idle_cnt == '0) begin
                n.failed        = 1'b1;
                hit             = 1'b1;
                res.out_kind    = KIND_ERROR;
                res.error_code  = ERR_TIMEOUT;
                res.packet_type = (st.ph == PH_PAYLOAD) ? st.cur_type : '0;
            end
            return n;
        end
        n.idle_cnt = c.idle_timeout_ticks;
        case (st.ph)
            PH_LENGTH: begin
                n.len_acc = st.len_acc | ({24'd0, it.rx_byte} << (8 * st.len_idx));
                n.len_idx = st.len_idx + 1'b1;
                if (n.len_idx == LEN_IDX_END) begin
                    if (n.len_acc[SIGN_BIT] || n.len_acc > {8'd0, c.max_packet_size}) begin
                        n.failed       = 1'b1;
                        hit            = 1'b1;
                        res.out_kind   = KIND_ERROR;
                        res.error_code = ERR_LENGTH;
                    end else begin
                        n.remain = n.len_acc[SIZE_W-1:0];
                        n.ph     = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                n.cur_type      = it.rx_byte;
                res.packet_type = it.rx_byte;
                if (it.rx_byte > c.max_valid_type) begin
                    n.failed       = 1'b1;
                    hit            = 1'b1;
                    res.out_kind   = KIND_ERROR;
                    res.error_code = ERR_TYPE;
                end else if (st.remain == '0) begin
                    n.ph         = PH_LENGTH;
                    n.len_acc    = '0;
                    n.len_idx    = '0;
                    hit          = 1'b1;
                    res.out_kind = KIND_EMPTY;
                    res.last     = 1'b1;
                end else begin
                    n.ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n.remain        = st.remain - 1'b1;
                hit             = 1'b1;
                res.out_kind    = KIND_DATA;
                res.packet_type = st.cur_type;
                res.data_byte   = it.rx_byte;
                res.last        = (n.remain == '0);
                if (res.last) begin
                    n.ph      = PH_LENGTH;
                    n.len_acc = '0;
                    n.len_idx = '0;
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    // queue a beat; beats that would raise an error are dropped unless allowed
    task automatic push_beat(input t_item it, input logic allow_fault);
        t_parser nx;
        logic    hit;
        t_result res;
        nx = deframe_step(plan_st, regs, it, hit, res);
        if (hit && res.out_kind == KIND_ERROR && !allow_fault)
            return;
        if (it.req_type == REQ_BYTE || plan_st.idle_cnt != '0)
            n_live_items++;
        plan_st = nx;
        rx_stream_q.push_back(it);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic allow_fault);
        t_item it;
        it.req_type = REQ_BYTE;
        it.rx_byte  = b;
        push_beat(it, allow_fault);
    endtask

    task automatic send_tick(input logic allow_fault);
        t_item it;
        it.req_type = REQ_TICK;
        it.rx_byte  = 8'($urandom_range(255));
        push_beat(it, allow_fault);
    endtask

    // a burst of timer ticks now and then
    task automatic maybe_ticks(input int pct);
        if ($urandom_range(99) < pct)
            repeat ($urandom_range(3, 1)) send_tick(1'b0);
    endtask

    // one well-formed frame: length prefix, type byte, payload
    task automatic send_frame(input logic [31:0] len, input logic [7:0] ptype,
                              input int tick_pct);
        for (int k = 0; k < LENGTH_BYTES_DEF; k++) begin
            maybe_ticks(tick_pct);
            send_byte(len[8*k +: 8], 1'b0);
        end
        maybe_ticks(tick_pct);
        send_byte(ptype, 1'b0);
        for (int k = 0; k < len; k++) begin
            maybe_ticks(tick_pct);
            send_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // random frames within the current limits, mostly short
    task automatic random_traffic(input int n_items);
        int unsigned lim;
        int unsigned hi;
        int unsigned len;
        int unsigned pick;
        logic [7:0]  ptype;
        n_live_items = 0;
        while (n_live_items < n_items) begin
            lim  = regs.max_packet_size;
            pick = $urandom_range(99);
            hi   = (pick < 80) ? 8 : (pick < 95) ? 40 : 64;
            hi   = (lim < hi) ? lim : hi;
            len  = $urandom_range(hi, 0);
            if (pick >= 97 && lim <= 64)
                len = lim;
            ptype = 8'($urandom_range(regs.max_valid_type, 0));
            if ($urandom_range(9) == 0)
                ptype = regs.max_valid_type;
            send_frame(len, ptype, 20);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // hold off until all beats are in and every result is out
    task automatic wait_drain();
        @(negedge i_clk);
        while (rx_stream_q.size() != 0 || s_axis_tvalid || deframed_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_MAX_SIZE: regs.max_packet_size    = val;
            CFG_TIMEOUT:  regs.idle_timeout_ticks = val;
            CFG_MAX_TYPE: regs.max_valid_type     = val[TYPE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // closing error of the run, then input the block has to ignore
    task automatic inject_fault();
        logic [31:0] len;
        logic [7:0]  frame_q[$];
        int          cut;
        fault_kind = t_fault'($urandom_range(3));
        case (fault_kind)
            FAULT_NEG_LEN: begin
                fault_name = "negative length";
                for (int k = 0; k < LENGTH_BYTES_DEF - 1; k++)
                    send_byte(8'($urandom_range(255)), 1'b1);
                send_byte(8'($urandom_range(255, 128)), 1'b1);
            end
            FAULT_BIG_LEN: begin
                fault_name = "oversize length";
                len = regs.max_packet_size + 1 + $urandom_range(1000);
                for (int k = 0; k < LENGTH_BYTES_DEF; k++)
                    send_byte(len[8*k +: 8], 1'b1);
            end
            FAULT_BAD_TYPE: begin
                fault_name = "invalid type";
                len = $urandom_range(3);
                for (int k = 0; k < LENGTH_BYTES_DEF; k++)
                    send_byte(len[8*k +: 8], 1'b1);
                send_byte(8'($urandom_range(255, regs.max_valid_type + 1)), 1'b1);
            end
            default: begin
                fault_name = "idle timeout";
                len = $urandom_range(6, 1);
                for (int k = 0; k < LENGTH_BYTES_DEF; k++)
                    frame_q.push_back(len[8*k +: 8]);
                frame_q.push_back(8'($urandom_range(regs.max_valid_type, 0)));
                for (int k = 0; k < len; k++)
                    frame_q.push_back(8'($urandom_range(255)));
                // stop somewhere inside or right after the frame
                cut = $urandom_range(frame_q.size(), 1);
                for (int k = 0; k < cut; k++)
                    send_byte(frame_q[k], 1'b1);
                while (!plan_st.failed)
                    send_tick(1'b1);
            end
        endcase
        repeat (20) begin
            if ($urandom_range(1))
                send_tick(1'b1);
            else
                send_byte(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            n_fail++;
        end
    endtask

    // input driver and receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (rx_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = rx_stream_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_beat.rx_byte;
                    s_axis_tuser  <= next_beat.req_type;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker first, then prediction for the beat accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (deframed_q.size() == 0) begin
                    $error("result beat with nothing expected: tdata 0x%0h tuser %0d",
                           m_axis_tdata, m_axis_tuser);
                    n_fail++;
                end else begin
                    want_res            = deframed_q.pop_front();
                    got_res.out_kind    = t_kind'(m_axis_tuser[KIND_W-1:0]);
                    got_res.packet_type = m_axis_tdata[7:0];
                    got_res.data_byte   = m_axis_tdata[15:8];
                    got_res.error_code  = t_err'(m_axis_tdata[17:16]);
                    got_res.last        = m_axis_tlast;
                    check_field("out_kind", want_res.out_kind, got_res.out_kind);
                    check_field("packet_type", want_res.packet_type, got_res.packet_type);
                    check_field("data_byte", want_res.data_byte, got_res.data_byte);
                    check_field("last", want_res.last, got_res.last);
                    check_field("error_code", want_res.error_code, got_res.error_code);
                    case (want_res.out_kind)
                        KIND_DATA:  n_payload++;
                        KIND_EMPTY: n_empty++;
                        default:    n_faults++;
                    endcase
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen_beat.req_type = t_req'(s_axis_tuser[0]);
                seen_beat.rx_byte  = s_axis_tdata[BYTE_W-1:0];
                live_st = deframe_step(live_st, regs, seen_beat, pred_hit, pred_res);
                if (pred_hit)
                    deframed_q.push_back(pred_res);
                n_beats_in++;
            end
        end
    end

    // watchdog on cycles without any beat moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("stream stalled for %0d cycles, %0d results outstanding",
                     stall_cycles, deframed_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        regs.max_packet_size    = MAX_SIZE_RST;
        regs.idle_timeout_ticks = TIMEOUT_RST;
        regs.max_valid_type     = MAX_TYPE_RST;
        plan_st                 = '0;
        plan_st.ph              = PH_LENGTH;
        live_st                 = plan_st;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: stopped timer, empty frame, extreme types and payload bytes
        send_tick(1'b0);
        send_frame(0, 8'd0, 0);
        send_frame(1, MAX_TYPE_RST, 0);
        send_tick(1'b0);
        for (int k = 0; k < LENGTH_BYTES_DEF; k++)
            send_byte((k == 0) ? 8'd3 : 8'd0, 1'b0);
        send_byte(8'd3, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hFF, 1'b0);

        set_idling(0, 0);
        random_traffic(200);

        // only empty frames allowed, any type code, short timer
        wait_drain();
        write_reg(CFG_MAX_SIZE, 24'd0);
        write_reg(CFG_TIMEOUT, 24'd3);
        write_reg(CFG_MAX_TYPE, 24'd255);
        set_idling(50, 0);
        random_traffic(200);

        // widest limits, only type zero
        wait_drain();
        write_reg(CFG_MAX_SIZE, 24'hFFFFFF);
        write_reg(CFG_TIMEOUT, 24'hFFFFFF);
        write_reg(CFG_MAX_TYPE, 24'd0);
        set_idling(0, 50);
        random_traffic(200);

        // one-tick timer, small frames, dead register write
        wait_drain();
        write_reg(CFG_MAX_SIZE, 24'd5);
        write_reg(CFG_TIMEOUT, 24'd1);
        write_reg(CFG_MAX_TYPE, 24'd8);
        write_reg(CFG_NONE_IDX, 24'($urandom_range(24'hFFFFFF)));
        set_idling(22, 22);
        random_traffic(200);

        // random limits
        wait_drain();
        write_reg(CFG_MAX_SIZE, 24'($urandom_range(64, 1)));
        write_reg(CFG_TIMEOUT, 24'($urandom_range(40, 2)));
        write_reg(CFG_MAX_TYPE, 24'($urandom_range(254, 1)));
        set_idling(0, 0);
        random_traffic(200);

        // back to the power-up values
        wait_drain();
        write_reg(CFG_MAX_SIZE, MAX_SIZE_RST);
        write_reg(CFG_TIMEOUT, TIMEOUT_RST);
        write_reg(CFG_MAX_TYPE, {16'd0, MAX_TYPE_RST});
        set_idling(22, 22);
        random_traffic(200);

        wait_drain();
        write_reg(CFG_TIMEOUT, 24'($urandom_range(6, 1)));
        inject_fault();

        wait_drain();
        repeat (8) @(negedge i_clk);

        $display("deframer: %0d input beats, %0d payload, %0d empty-frame, %0d error results",
                 n_beats_in, n_payload, n_empty, n_faults);
        $display("six register settings, closing error: %s", fault_name);
        if (n_fail == 0 && deframed_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
